[rtl/lcu_pkg.sv]
`default_nettype none
package lcu_pkg;

    localparam int QW = 32;

    // Shared multiplier operand and product widths.
    localparam int MUL_AW = 35;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Operation codes carried in the request.
    localparam logic [2:0] FN_PITCH   = 3'd0;
    localparam logic [2:0] FN_YAW     = 3'd1;
    localparam logic [2:0] FN_RIGHT   = 3'd2;
    localparam logic [2:0] FN_UP      = 3'd3;
    localparam logic [2:0] FN_FORWARD = 3'd4;

    localparam int Q_ONE        = 65536;
    localparam int FULL_TURN    = 23592960;
    localparam int HALF_TURN    = 11796480;
    localparam int QUARTER_TURN = 5898240;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_GAIN  = 652032874;

    localparam logic signed [25:0] ATAN_DEG [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115
    };

    localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
    localparam logic signed [51:0] SAT_MIN = -SAT_MAX - 52'sd1;

    function automatic logic signed [QW-1:0] sat32(input logic signed [51:0] v);
        logic signed [QW-1:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/lookat_camera_update.sv]
`default_nettype none
// Channel   | Direction | Payload
// s_axis    | in        | tdata[2:0] func, tdata[34:3] amount, tdata[39:35] zero
// m_axis    | out       | tdata: eye x,y,z, target x,y,z, up x,y,z, 32 bits each, low first
//
// One request at a time; tready is high only while the sequencer is idle.
// A normalisation takes up to 29 scaling steps, three squares, a square root and three
// divides; a zero vector skips all of them.
// Reset (synchronous, active low) restores the camera to its start position; a finished
// result waits in the output register while the next request is taken.
module lookat_camera_update import lcu_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire  [39:0]  i_s_axis_tdata,   // func[2:0], amount[34:3]
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    output logic [287:0] o_m_axis_tdata    // eye x,y,z, target x,y,z, up x,y,z
);

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_NZ   = 15'b000000000000010,
        ST_NSH  = 15'b000000000000100,
        ST_MUL  = 15'b000000000001000,
        ST_SQRT = 15'b000000000010000,
        ST_SQW  = 15'b000000000100000,
        ST_DIV  = 15'b000000001000000,
        ST_DIVW = 15'b000000010000000,
        ST_NEXT = 15'b000000100000000,
        ST_CORD = 15'b000001000000000,
        ST_CORW = 15'b000010000000000,
        ST_TGT  = 15'b000100000000000,
        ST_DONE = 15'b001000000000000,
        ST_SPR1 = 15'b010000000000000,
        ST_SPR2 = 15'b100000000000000
    } t_state;

    typedef enum logic [7:0] {
        PH_VIEW  = 8'b00000001,
        PH_XUV   = 8'b00000010,
        PH_RIGHT = 8'b00000100,
        PH_CORD  = 8'b00001000,
        PH_NV    = 8'b00010000,
        PH_XNR   = 8'b00100000,
        PH_STEP  = 8'b01000000,
        PH_MOVE  = 8'b10000000
    } t_phase;

    typedef enum logic [1:0] {
        JB_SQ    = 2'd0,
        JB_CROSS = 2'd1,
        JB_NV    = 2'd2,
        JB_MOVE  = 2'd3
    } t_job;

    t_state r_state;
    t_phase r_ph;
    t_job   r_job;

    logic [2:0]  r_func;
    logic signed [QW-1:0] r_amt;
    logic signed [QW-1:0] r_eye [3];
    logic signed [QW-1:0] r_tgt [3];
    logic signed [QW-1:0] r_up  [3];

    logic signed [35:0] r_w     [3];
    logic [35:0]        r_m;
    logic signed [17:0] r_nrm   [3];
    logic signed [17:0] r_view  [3];
    logic signed [17:0] r_right [3];
    logic signed [17:0] r_step  [3];
    logic signed [34:0] r_nv    [3];
    logic signed [34:0] r_ca    [3];
    logic signed [17:0] r_cb    [3];
    logic signed [17:0] r_cos;
    logic signed [17:0] r_sin;
    logic signed [67:0] r_acc;
    logic [63:0]        r_sum;
    logic [QW-1:0]      r_len;
    logic [1:0]         r_dk;
    logic [2:0]         r_mk;
    logic               r_mph;
    logic               r_ovalid;
    logic [287:0]       r_odata;

    // Shared units.
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    logic        sq_start, sq_done;
    logic [QW-1:0] sq_root;
    logic        dv_start, dv_done;
    logic [16:0] dv_quo;
    logic [QW-1:0] dv_num;
    logic        cd_start, cd_done;
    logic signed [17:0] cd_cos, cd_sin;

    lcu_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    lcu_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (r_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    lcu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (r_len),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    lcu_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_angle (r_amt),
        .o_done  (cd_done),
        .o_cos   (cd_cos),
        .o_sin   (cd_sin)
    );

    assign sq_start = (r_state == ST_SQRT);
    assign dv_start = (r_state == ST_DIV);
    assign cd_start = (r_state == ST_CORD);
    assign dv_num   = r_w[r_dk][35] ? QW'(-r_w[r_dk]) : QW'(r_w[r_dk]);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // Cross product term selection: component c uses indices (i, j) cyclically after c.
    logic [1:0] mc, ci, cj, ka, kb;
    logic       msub;
    logic       mlast;

    always_comb begin
        mc   = r_mk[2:1];
        msub = r_mk[0];
        unique case (mc)
            2'd0:    begin ci = 2'd1; cj = 2'd2; end
            2'd1:    begin ci = 2'd2; cj = 2'd0; end
            default: begin ci = 2'd0; cj = 2'd1; end
        endcase
        ka = msub ? cj : ci;
        kb = msub ? ci : cj;
        mul_a = '0;
        mul_b = '0;
        unique case (r_job)
            JB_SQ: begin
                mul_a = r_w[r_mk[1:0]][MUL_AW-1:0];
                mul_b = r_w[r_mk[1:0]][MUL_BW-1:0];
            end
            JB_CROSS: begin
                mul_a = r_ca[ka];
                mul_b = MUL_BW'(r_cb[kb]);
            end
            JB_NV: begin
                if (!msub) begin
                    mul_a = MUL_AW'(r_view[mc]);
                    mul_b = MUL_BW'(r_cos);
                end else begin
                    mul_a = (r_func == FN_PITCH) ? MUL_AW'(r_up[mc]) : MUL_AW'(r_right[mc]);
                    mul_b = MUL_BW'(r_sin);
                end
            end
            default: begin
                mul_a = MUL_AW'(r_step[r_mk[1:0]]);
                mul_b = r_amt;
            end
        endcase
        unique case (r_job)
            JB_SQ, JB_MOVE: mlast = (r_mk == 3'd2);
            default:        mlast = (r_mk == 3'd5);
        endcase
    end

    logic [35:0] wmag [3];
    logic [35:0] wmax;
    logic signed [67:0] pq;
    logic signed [67:0] pdiff;
    logic signed [50:0] mv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wmag[i] = r_w[i][35] ? 36'(-r_w[i]) : 36'(r_w[i]);
        end
        wmax = wmag[0];
        if (wmag[1] > wmax) wmax = wmag[1];
        if (wmag[2] > wmax) wmax = wmag[2];
        pq    = 68'(mul_p >>> 16);
        pdiff = r_acc - 68'(mul_p);
        mv    = 51'(mul_p >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ph     <= PH_VIEW;
            r_job    <= JB_SQ;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_eye[i] <= 32'(Q_ONE);
                r_tgt[i] <= '0;
                r_up[i]  <= (i == 1) ? 32'(Q_ONE) : '0;
            end
        end else begin
            // In ST_DONE the output register is reloaded instead.
            if (r_ovalid && i_m_axis_tready && r_state != ST_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_func <= i_s_axis_tdata[2:0];
                        r_amt  <= i_s_axis_tdata[34:3];
                        priority if (i_s_axis_tdata[2:0] <= FN_RIGHT) begin
                            for (int i = 0; i < 3; i++) r_w[i] <= 36'(r_tgt[i]) - 36'(r_eye[i]);
                            r_ph    <= PH_VIEW;
                            r_state <= ST_NZ;
                        end else if (i_s_axis_tdata[2:0] == FN_UP) begin
                            for (int i = 0; i < 3; i++) r_w[i] <= 36'(r_up[i]);
                            r_ph    <= PH_STEP;
                            r_state <= ST_NZ;
                        end else if (i_s_axis_tdata[2:0] == FN_FORWARD) begin
                            for (int i = 0; i < 3; i++) r_w[i] <= 36'(r_tgt[i]) - 36'(r_eye[i]);
                            r_ph    <= PH_STEP;
                            r_state <= ST_NZ;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                // Normalisation: zero check, power-of-two scaling, squares, root, divides.
                ST_NZ: begin
                    if (wmax == '0) begin
                        for (int i = 0; i < 3; i++) r_nrm[i] <= '0;
                        r_state <= ST_NEXT;
                    end else begin
                        r_m     <= wmax;
                        r_state <= ST_NSH;
                    end
                end
                ST_NSH: begin
                    if (r_m[35:30] != '0) begin
                        for (int i = 0; i < 3; i++) r_w[i] <= r_w[i] >>> 1;
                        r_m <= r_m >> 1;
                    end else if (r_m[35:29] == '0) begin
                        for (int i = 0; i < 3; i++) r_w[i] <= r_w[i] <<< 1;
                        r_m <= r_m << 1;
                    end else begin
                        r_sum   <= '0;
                        r_job   <= JB_SQ;
                        r_mk    <= '0;
                        r_mph   <= 1'b0;
                        r_state <= ST_MUL;
                    end
                end
                ST_SQRT: r_state <= ST_SQW;
                ST_SQW: begin
                    if (sq_done) begin
                        r_len   <= sq_root;
                        r_dk    <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: r_state <= ST_DIVW;
                ST_DIVW: begin
                    if (dv_done) begin
                        r_nrm[r_dk] <= r_w[r_dk][35] ? -18'(dv_quo) : 18'(dv_quo);
                        if (r_dk == 2'd2) begin
                            r_state <= ST_NEXT;
                        end else begin
                            r_dk    <= r_dk + 2'd1;
                            r_state <= ST_DIV;
                        end
                    end
                end
                // Shared multiplier: operands with r_mph low, product taken with r_mph high.
                ST_MUL: begin
                    if (!r_mph) begin
                        r_mph <= 1'b1;
                    end else begin
                        r_mph <= 1'b0;
                        r_mk  <= r_mk + 3'd1;
                        unique case (r_job)
                            JB_SQ: r_sum <= r_sum + mul_p[63:0];
                            JB_CROSS: begin
                                if (!msub) r_acc <= 68'(mul_p);
                                else       r_w[mc] <= 36'(pdiff >>> 16);
                            end
                            JB_NV: begin
                                if (!msub) r_acc <= pq;
                                else       r_nv[mc] <= 35'(r_acc + pq);
                            end
                            default: begin
                                r_eye[r_mk[1:0]] <= sat32(52'(r_eye[r_mk[1:0]]) + 52'(mv));
                                r_tgt[r_mk[1:0]] <= sat32(52'(r_tgt[r_mk[1:0]]) + 52'(mv));
                            end
                        endcase
                        if (mlast) begin
                            r_state <= (r_job == JB_SQ) ? ST_SQRT : ST_NEXT;
                        end
                    end
                end
                ST_NEXT: begin
                    r_mk  <= '0;
                    r_mph <= 1'b0;
                    unique case (r_ph)
                        PH_VIEW: begin
                            for (int i = 0; i < 3; i++) begin
                                r_view[i] <= r_nrm[i];
                                r_ca[i]   <= 35'(r_up[i]);
                                r_cb[i]   <= r_nrm[i];
                            end
                            r_job   <= JB_CROSS;
                            r_ph    <= PH_XUV;
                            r_state <= ST_MUL;
                        end
                        PH_XUV: begin
                            r_ph    <= PH_RIGHT;
                            r_state <= ST_NZ;
                        end
                        PH_RIGHT: begin
                            for (int i = 0; i < 3; i++) begin
                                r_right[i] <= r_nrm[i];
                                r_step[i]  <= r_nrm[i];
                            end
                            if (r_func == FN_RIGHT) begin
                                r_job   <= JB_MOVE;
                                r_ph    <= PH_MOVE;
                                r_state <= ST_MUL;
                            end else begin
                                r_ph    <= PH_CORD;
                                r_state <= ST_CORD;
                            end
                        end
                        PH_CORD: begin
                            r_job   <= JB_NV;
                            r_ph    <= PH_NV;
                            r_state <= ST_MUL;
                        end
                        PH_NV: begin
                            if (r_func == FN_PITCH) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_ca[i] <= r_nv[i];
                                    r_cb[i] <= r_right[i];
                                end
                                r_job   <= JB_CROSS;
                                r_ph    <= PH_XNR;
                                r_state <= ST_MUL;
                            end else begin
                                r_state <= ST_TGT;
                            end
                        end
                        PH_XNR: begin
                            for (int i = 0; i < 3; i++) r_up[i] <= sat32(52'(r_w[i]));
                            r_state <= ST_TGT;
                        end
                        PH_STEP: begin
                            for (int i = 0; i < 3; i++) r_step[i] <= r_nrm[i];
                            r_job   <= JB_MOVE;
                            r_ph    <= PH_MOVE;
                            r_state <= ST_MUL;
                        end
                        default: r_state <= ST_DONE;
                    endcase
                end
                ST_CORD: r_state <= ST_CORW;
                ST_CORW: begin
                    if (cd_done) begin
                        r_cos   <= cd_cos;
                        r_sin   <= cd_sin;
                        r_state <= ST_NEXT;
                    end
                end
                ST_TGT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_tgt[i] <= sat32(52'(r_eye[i]) + 52'(r_nv[i]));
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_odata  <= {r_up[2], r_up[1], r_up[0],
                                     r_tgt[2], r_tgt[1], r_tgt[0],
                                     r_eye[2], r_eye[1], r_eye[0]};
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/lcu_mul.sv]
`default_nettype none
module lcu_mul import lcu_pkg::*; (
    input  wire                       i_clk,
    input  wire logic signed [MUL_AW-1:0] i_a,
    input  wire logic signed [MUL_BW-1:0] i_b,
    output logic signed [MUL_PW-1:0]  o_p
);

    // Registered product: the sequencer reads it in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        o_p <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

endmodule
`default_nettype wire

[rtl/lcu_isqrt.sv]
`default_nettype none
module lcu_isqrt import lcu_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire logic [63:0]  i_n,
    output logic              o_done,
    output logic [QW-1:0]     o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_n;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] sumv;

    assign sumv   = r_res + r_bit;
    assign o_done = r_done;
    assign o_root = r_res[QW-1:0];

    // One result bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_n    <= i_n;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if (r_n >= sumv) begin
                    r_n   <= r_n - sumv;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/lcu_div.sv]
`default_nettype none
module lcu_div import lcu_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire logic [QW-1:0] i_num,
    input  wire logic [QW-1:0] i_den,
    output logic              o_done,
    output logic [16:0]       o_quo
);

    logic        r_busy;
    logic        r_done;
    logic        r_first;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [QW-1:0] r_den;
    logic [16:0] r_quo;
    logic [32:0] sh;

    // The numerator never exceeds the divisor, so 17 quotient bits cover num*2^16/den.
    assign sh     = r_first ? r_rem : {r_rem[31:0], 1'b0};
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= {1'b0, i_num};
                r_den   <= i_den;
                r_quo   <= '0;
            end else if (r_busy) begin
                r_first <= 1'b0;
                if (sh >= {1'b0, r_den}) begin
                    r_rem <= sh - {1'b0, r_den};
                    r_quo <= {r_quo[15:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_quo <= {r_quo[15:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/lcu_cordic.sv]
`default_nettype none
module lcu_cordic import lcu_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire logic signed [QW-1:0] i_angle,
    output logic                 o_done,
    output logic signed [17:0]   o_cos,
    output logic signed [17:0]   o_sin
);

    typedef enum logic [5:0] {
        CS_IDLE = 6'b000001,
        CS_RED  = 6'b000010,
        CS_FIX  = 6'b000100,
        CS_FOLD = 6'b001000,
        CS_ROT  = 6'b010000,
        CS_OUT  = 6'b100000
    } t_cstate;

    localparam logic signed [25:0] FULL26    = 26'(FULL_TURN);
    localparam logic signed [25:0] HALF26    = 26'(HALF_TURN);
    localparam logic signed [25:0] QUARTER26 = 26'(QUARTER_TURN);

    t_cstate r_state;
    logic    r_done;
    logic    r_neg;
    logic    r_flip;
    logic [3:0] r_k;
    logic [QW-1:0] r_mag;
    logic signed [25:0] r_ang;
    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [17:0] r_cos;
    logic signed [17:0] r_sin;

    logic [QW-1:0]      red_sub;
    logic signed [25:0] pos;
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [32:0] xr;
    logic signed [32:0] yr;

    assign red_sub = 32'(FULL_TURN) << r_k[2:0];
    assign pos     = (r_neg && r_mag != '0) ? FULL26 - 26'(r_mag) : 26'(r_mag);
    assign xs      = r_x >>> r_k;
    assign ys      = r_y >>> r_k;
    assign xr      = (r_x + 33'sd8192) >>> 14;
    assign yr      = (r_y + 33'sd8192) >>> 14;

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                CS_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_angle[QW-1];
                        r_mag   <= i_angle[QW-1] ? QW'(-i_angle) : QW'(i_angle);
                        r_k     <= 4'd6;
                        r_state <= CS_RED;
                    end
                end
                // Magnitude modulo a full turn by restoring subtraction of shifted turns.
                CS_RED: begin
                    if (r_mag >= red_sub) begin
                        r_mag <= r_mag - red_sub;
                    end
                    if (r_k == 4'd0) begin
                        r_state <= CS_FIX;
                    end else begin
                        r_k <= r_k - 4'd1;
                    end
                end
                CS_FIX: begin
                    r_ang   <= (pos >= HALF26) ? pos - FULL26 : pos;
                    r_state <= CS_FOLD;
                end
                // Fold into a half turn around zero; the fold negates both results.
                CS_FOLD: begin
                    if (r_ang > QUARTER26) begin
                        r_ang  <= r_ang - HALF26;
                        r_flip <= 1'b1;
                    end else if (r_ang < -QUARTER26) begin
                        r_ang  <= r_ang + HALF26;
                        r_flip <= 1'b1;
                    end else begin
                        r_flip <= 1'b0;
                    end
                    r_x     <= 33'(CORDIC_GAIN);
                    r_y     <= '0;
                    r_k     <= '0;
                    r_state <= CS_ROT;
                end
                CS_ROT: begin
                    if (r_ang >= 0) begin
                        r_x   <= r_x - ys;
                        r_y   <= r_y + xs;
                        r_ang <= r_ang - ATAN_DEG[r_k];
                    end else begin
                        r_x   <= r_x + ys;
                        r_y   <= r_y - xs;
                        r_ang <= r_ang + ATAN_DEG[r_k];
                    end
                    if (r_k == 4'(CORDIC_STEPS - 1)) begin
                        r_state <= CS_OUT;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                CS_OUT: begin
                    r_cos   <= r_flip ? 18'(-xr) : 18'(xr);
                    r_sin   <= r_flip ? 18'(-yr) : 18'(yr);
                    r_done  <= 1'b1;
                    r_state <= CS_IDLE;
                end
                default: r_state <= CS_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
